[rtl/float_elementwise_alu_core_defines.svh]
// assertion macros for the binary32 element-wise unit
`ifndef FLOAT_ELEMENTWISE_ALU_CORE_DEFINES_SVH
`define FLOAT_ELEMENTWISE_ALU_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define FEAC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define FEAC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define FEAC_ASSERT_IMP(lbl, ante, cons, msg)
`define FEAC_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/feac_pkg.sv]
// shared types, constants and helper functions of the binary32 element-wise unit
`default_nettype none
package feac_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_DIV = 2'd1,
    OP_MUL = 2'd2,
    OP_SUB = 2'd3
  } op_t;

  localparam logic [1:0] REG_OP_MODE  = 2'd0;
  localparam logic [1:0] REG_USE_SCAL = 2'd1;
  localparam logic [1:0] REG_REVERSE  = 2'd2;
  localparam logic [1:0] REG_SCALAR   = 2'd3;

  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
  localparam int DIV_STEPS = 26;

  typedef struct packed {
    logic               nan;
    logic               inf;
    logic               zero;
    logic               sign;
    logic signed [9:0]  exp;
    logic [23:0]        man;
  } opnd_t;

  typedef struct packed {
    logic        last;
    op_t         op;
    logic [31:0] x;
    logic [31:0] y;
  } sel_t;

  typedef struct packed {
    logic               last;
    op_t                op;
    logic               spec;
    logic [31:0]        spec_val;
    logic               sx;
    logic               sy;
    logic signed [9:0]  ex;
    logic signed [9:0]  ey;
    logic [23:0]        mx;
    logic [23:0]        my;
  } unp_t;

  typedef struct packed {
    logic               last;
    op_t                op;
    logic               spec;
    logic [31:0]        spec_val;
    logic               sign;
    logic signed [9:0]  exp;
    logic [26:0]        big;
    logic [26:0]        small_m;
    logic               eff_sub;
    logic [47:0]        prod;
    logic [25:0]        rem;
    logic [23:0]        dvs;
  } frt_t;

  typedef struct packed {
    logic               last;
    logic               is_add;
    logic               is_div;
    logic               spec;
    logic [31:0]        spec_val;
    logic               sign;
    logic signed [9:0]  exp;
    logic [27:0]        sum;
    logic [25:0]        sig;
    logic               sticky;
    logic [25:0]        rem;
    logic [23:0]        dvs;
  } ads_t;

  typedef struct packed {
    logic               last;
    logic               is_div;
    logic               spec;
    logic [31:0]        spec_val;
    logic               sign;
    logic signed [9:0]  exp;
    logic [25:0]        sig;
    logic               sticky;
    logic [25:0]        rem;
    logic [23:0]        dvs;
  } mid_t;

  typedef struct packed {
    logic        last;
    logic        spec;
    logic [31:0] spec_val;
    logic        ovf;
    logic        sign;
    logic [7:0]  ef;
    logic [25:0] sig;
    logic        sticky;
  } rn_t;

  function automatic logic [4:0] lzc24(input logic [23:0] v);
    logic [4:0] n;
    logic       found;
    n = 5'd24;
    found = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 5'(23 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] n;
    logic       found;
    n = 5'd27;
    found = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 5'(26 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic opnd_t unpack(input logic [31:0] w);
    opnd_t      o;
    logic [4:0] lz;
    o.sign = w[31];
    o.nan  = (&w[30:23]) && (|w[22:0]);
    o.inf  = (&w[30:23]) && !(|w[22:0]);
    o.zero = !(|w[30:0]);
    lz = lzc24({1'b0, w[22:0]});
    if (|w[30:23]) begin
      o.man = {1'b1, w[22:0]};
      o.exp = signed'({2'b00, w[30:23]});
    end else begin
      // subnormal: normalize so the hidden bit is set
      o.man = {1'b0, w[22:0]} << lz;
      o.exp = 10'sd1 - signed'({5'b00000, lz});
    end
    return o;
  endfunction

endpackage
`default_nettype wire

[rtl/float_elementwise_alu_core.sv]
// binary32 add, subtract, multiply and divide on a word stream, fully pipelined
//
//  channel | handshake                 | payload
//  in      | in_tvalid / in_tready     | in_tdata {second_operand, first_operand}, in_tlast
//  out     | out_tvalid / out_tready   | out_tdata result_value, out_tlast
//  cfg     | apb write, pready high    | op_mode, use_scalar, reverse_operands, scalar_value
//
// one word enters per cycle unless the output stalls; every operation passes through the same stages
// depth is set by the divider, which resolves one quotient bit per stage (26 stages)
// the whole pipeline advances when the output register is empty or being taken
// a stall at the output holds every stage, nothing is dropped or repeated
// reset (synchronous, active low) clears valid bits and the configuration registers
`default_nettype none
`include "float_elementwise_alu_core_defines.svh"
module float_elementwise_alu_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [31:0] first_operand, [63:32] second_operand
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] result_value
  output logic             out_tlast,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int NSTG = feac_pkg::DIV_STEPS;

  // configuration
  feac_pkg::op_t op_mode_r;
  logic          use_scalar_r;
  logic          reverse_r;
  logic [31:0]   scalar_r;
  logic          cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_mode_r    <= feac_pkg::OP_ADD;
      use_scalar_r <= 1'b0;
      reverse_r    <= 1'b0;
      scalar_r     <= 32'd0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        feac_pkg::REG_OP_MODE:  op_mode_r    <= feac_pkg::op_t'(cfg_pwdata[1:0]);
        feac_pkg::REG_USE_SCAL: use_scalar_r <= cfg_pwdata[0];
        feac_pkg::REG_REVERSE:  reverse_r    <= cfg_pwdata[0];
        feac_pkg::REG_SCALAR:   scalar_r     <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      feac_pkg::REG_OP_MODE:  cfg_prdata = {30'd0, op_mode_r};
      feac_pkg::REG_USE_SCAL: cfg_prdata = {31'd0, use_scalar_r};
      feac_pkg::REG_REVERSE:  cfg_prdata = {31'd0, reverse_r};
      feac_pkg::REG_SCALAR:   cfg_prdata = scalar_r;
      default:                cfg_prdata = 32'd0;
    endcase
  end

  // pipeline control
  logic adv;
  logic out_vld_r;
  assign adv = !out_vld_r || out_tready;
  assign in_tready = adv;

  // stage 1: operand selection, subtract folded into add
  feac_pkg::sel_t sel_r, sel_nxt;
  logic           sel_vld_r;

  always_comb begin
    logic [31:0] a;
    logic [31:0] b;
    a = in_tdata[31:0];
    b = in_tdata[63:32];
    sel_nxt.last = in_tlast;
    sel_nxt.x = a;
    sel_nxt.y = b;
    if (use_scalar_r) begin
      sel_nxt.x = reverse_r ? scalar_r : a;
      sel_nxt.y = reverse_r ? a : scalar_r;
    end
    sel_nxt.op = op_mode_r;
    if (op_mode_r == feac_pkg::OP_SUB) begin
      sel_nxt.y[31] = ~sel_nxt.y[31];
      sel_nxt.op = feac_pkg::OP_ADD;
    end
  end

  // stage 2: unpack and special values
  feac_pkg::unp_t unp_r, unp_nxt;
  logic           unp_vld_r;

  always_comb begin
    feac_pkg::opnd_t ox;
    feac_pkg::opnd_t oy;
    logic            sg;
    ox = feac_pkg::unpack(sel_r.x);
    oy = feac_pkg::unpack(sel_r.y);
    sg = ox.sign ^ oy.sign;
    unp_nxt.last = sel_r.last;
    unp_nxt.op = sel_r.op;
    unp_nxt.sx = ox.sign;
    unp_nxt.sy = oy.sign;
    unp_nxt.ex = ox.exp;
    unp_nxt.ey = oy.exp;
    unp_nxt.mx = ox.man;
    unp_nxt.my = oy.man;
    unp_nxt.spec = 1'b1;
    unp_nxt.spec_val = feac_pkg::CANON_NAN;
    case (sel_r.op) inside
      feac_pkg::OP_ADD, feac_pkg::OP_SUB: begin
        if (ox.nan || oy.nan || (ox.inf && oy.inf && (ox.sign != oy.sign)))
          unp_nxt.spec_val = feac_pkg::CANON_NAN;
        else if (ox.inf)               unp_nxt.spec_val = sel_r.x;
        else if (oy.inf)               unp_nxt.spec_val = sel_r.y;
        else if (ox.zero && oy.zero)   unp_nxt.spec_val = {ox.sign & oy.sign, 31'd0};
        else if (ox.zero)              unp_nxt.spec_val = sel_r.y;
        else if (oy.zero)              unp_nxt.spec_val = sel_r.x;
        else                           unp_nxt.spec = 1'b0;
      end
      feac_pkg::OP_MUL: begin
        if (ox.nan || oy.nan || (ox.inf && oy.zero) || (ox.zero && oy.inf))
          unp_nxt.spec_val = feac_pkg::CANON_NAN;
        else if (ox.inf || oy.inf)     unp_nxt.spec_val = {sg, 8'hFF, 23'd0};
        else if (ox.zero || oy.zero)   unp_nxt.spec_val = {sg, 31'd0};
        else                           unp_nxt.spec = 1'b0;
      end
      default: begin
        if (ox.nan || oy.nan || (ox.inf && oy.inf) || (ox.zero && oy.zero))
          unp_nxt.spec_val = feac_pkg::CANON_NAN;
        else if (ox.inf)               unp_nxt.spec_val = {sg, 8'hFF, 23'd0};
        else if (oy.inf)               unp_nxt.spec_val = {sg, 31'd0};
        else if (oy.zero)              unp_nxt.spec_val = {sg, 8'hFF, 23'd0};
        else if (ox.zero)              unp_nxt.spec_val = {sg, 31'd0};
        else                           unp_nxt.spec = 1'b0;
      end
    endcase
  end

  // stage 3: alignment, multiply, divider setup
  feac_pkg::frt_t frt_r, frt_nxt;
  logic           frt_vld_r;

  always_comb begin
    logic               x_big;
    logic [23:0]        bm;
    logic [23:0]        sm;
    logic signed [9:0]  be;
    logic signed [9:0]  d;
    logic [5:0]         dcap;
    logic [50:0]        wide;
    logic               ge;
    x_big = (unp_r.ex > unp_r.ey) || ((unp_r.ex == unp_r.ey) && (unp_r.mx >= unp_r.my));
    bm = x_big ? unp_r.mx : unp_r.my;
    sm = x_big ? unp_r.my : unp_r.mx;
    be = x_big ? unp_r.ex : unp_r.ey;
    d  = x_big ? (unp_r.ex - unp_r.ey) : (unp_r.ey - unp_r.ex);
    dcap = (d > 10'sd50) ? 6'd50 : d[5:0];
    // shifted-out bits collapse into a sticky lsb
    wide = {sm, 27'd0} >> dcap;
    ge = unp_r.mx >= unp_r.my;

    frt_nxt.last = unp_r.last;
    frt_nxt.op = unp_r.op;
    frt_nxt.spec = unp_r.spec;
    frt_nxt.spec_val = unp_r.spec_val;
    frt_nxt.big = {bm, 3'b000};
    frt_nxt.small_m = {wide[50:25], wide[24] | (|wide[23:0])};
    frt_nxt.eff_sub = unp_r.sx ^ unp_r.sy;
    frt_nxt.prod = unp_r.mx * unp_r.my;
    frt_nxt.rem = ge ? {2'b00, unp_r.mx} : {1'b0, unp_r.mx, 1'b0};
    frt_nxt.dvs = unp_r.my;
    case (unp_r.op)
      feac_pkg::OP_MUL: begin
        frt_nxt.sign = unp_r.sx ^ unp_r.sy;
        frt_nxt.exp = unp_r.ex + unp_r.ey - 10'sd127;
      end
      feac_pkg::OP_DIV: begin
        frt_nxt.sign = unp_r.sx ^ unp_r.sy;
        frt_nxt.exp = unp_r.ex - unp_r.ey + (ge ? 10'sd127 : 10'sd126);
      end
      default: begin
        frt_nxt.sign = x_big ? unp_r.sx : unp_r.sy;
        frt_nxt.exp = be;
      end
    endcase
  end

  // stage 4: mantissa add, product normalize
  feac_pkg::ads_t ads_r, ads_nxt;
  logic           ads_vld_r;

  always_comb begin
    ads_nxt.last = frt_r.last;
    ads_nxt.is_add = (frt_r.op == feac_pkg::OP_ADD) || (frt_r.op == feac_pkg::OP_SUB);
    ads_nxt.is_div = frt_r.op == feac_pkg::OP_DIV;
    ads_nxt.spec = frt_r.spec;
    ads_nxt.spec_val = frt_r.spec_val;
    ads_nxt.sign = frt_r.sign;
    ads_nxt.exp = frt_r.exp;
    ads_nxt.sum = frt_r.eff_sub ? ({1'b0, frt_r.big} - {1'b0, frt_r.small_m})
                                : ({1'b0, frt_r.big} + {1'b0, frt_r.small_m});
    ads_nxt.rem = frt_r.rem;
    ads_nxt.dvs = frt_r.dvs;
    ads_nxt.sig = 26'd0;
    ads_nxt.sticky = 1'b0;
    if (frt_r.op == feac_pkg::OP_MUL) begin
      if (frt_r.prod[47]) begin
        ads_nxt.sig = frt_r.prod[47:22];
        ads_nxt.sticky = |frt_r.prod[21:0];
        ads_nxt.exp = frt_r.exp + 10'sd1;
      end else begin
        ads_nxt.sig = frt_r.prod[46:21];
        ads_nxt.sticky = |frt_r.prod[20:0];
      end
    end
  end

  // stage 5 and divider stages: dv_r[0] holds the normalized sum, dv_r[k] k quotient bits
  feac_pkg::mid_t dv_r   [0:NSTG];
  feac_pkg::mid_t dv_nxt [0:NSTG];
  logic           dv_vld_r [0:NSTG];

  always_comb begin
    logic [4:0]  lz;
    logic [26:0] sh;
    lz = feac_pkg::lzc27(ads_r.sum[26:0]);
    sh = ads_r.sum[26:0] << lz;
    dv_nxt[0].last = ads_r.last;
    dv_nxt[0].is_div = ads_r.is_div;
    dv_nxt[0].spec = ads_r.spec;
    dv_nxt[0].spec_val = ads_r.spec_val;
    dv_nxt[0].sign = ads_r.sign;
    dv_nxt[0].exp = ads_r.exp;
    dv_nxt[0].sig = ads_r.sig;
    dv_nxt[0].sticky = ads_r.sticky;
    dv_nxt[0].rem = ads_r.rem;
    dv_nxt[0].dvs = ads_r.dvs;
    if (ads_r.is_add && !ads_r.spec) begin
      if (ads_r.sum == 28'd0) begin
        // exact cancellation rounds to plus zero
        dv_nxt[0].spec = 1'b1;
        dv_nxt[0].spec_val = 32'd0;
      end else if (ads_r.sum[27]) begin
        dv_nxt[0].sig = ads_r.sum[27:2];
        dv_nxt[0].sticky = ads_r.sum[1] | ads_r.sum[0];
        dv_nxt[0].exp = ads_r.exp + 10'sd1;
      end else begin
        dv_nxt[0].sig = sh[26:1];
        dv_nxt[0].sticky = sh[0];
        dv_nxt[0].exp = ads_r.exp - signed'({5'b00000, lz});
      end
    end
  end

  for (genvar k = 0; k < NSTG; k++) begin : g_div
    always_comb begin
      logic        ge;
      logic [25:0] r1;
      ge = dv_r[k].rem >= {2'b00, dv_r[k].dvs};
      r1 = ge ? (dv_r[k].rem - {2'b00, dv_r[k].dvs}) : dv_r[k].rem;
      dv_nxt[k+1] = dv_r[k];
      if (dv_r[k].is_div && !dv_r[k].spec) begin
        dv_nxt[k+1].sig[NSTG-1-k] = ge;
        dv_nxt[k+1].rem = {r1[24:0], 1'b0};
      end
    end
  end

  // denormalize stage
  feac_pkg::rn_t rn_r, rn_nxt;
  logic          rn_vld_r;

  always_comb begin
    feac_pkg::mid_t     m;
    logic signed [10:0] shamt;
    logic [4:0]         sh5;
    logic [52:0]        wide;
    m = dv_r[NSTG];
    shamt = 11'sd1 - signed'({m.exp[9], m.exp});
    sh5 = (shamt > 11'sd27) ? 5'd27 : shamt[4:0];
    wide = {m.sig, 27'd0} >> sh5;
    rn_nxt.last = m.last;
    rn_nxt.spec = m.spec;
    rn_nxt.spec_val = m.spec_val;
    rn_nxt.sign = m.sign;
    rn_nxt.ovf = m.exp > 10'sd254;
    rn_nxt.sticky = m.sticky | (m.is_div & (|m.rem));
    rn_nxt.sig = m.sig;
    rn_nxt.ef = m.exp[7:0];
    if (m.exp < 10'sd1) begin
      rn_nxt.sig = wide[52:27];
      rn_nxt.sticky = m.sticky | (m.is_div & (|m.rem)) | (|wide[26:0]);
      rn_nxt.ef = 8'd0;
    end
  end

  // round and pack into the output register
  logic [31:0] out_data_r, out_data_nxt;
  logic        out_last_r;

  always_comb begin
    logic        up;
    logic [30:0] word;
    // carry out of the fraction moves into the exponent field
    up = rn_r.sig[1] & (rn_r.sig[0] | rn_r.sticky | rn_r.sig[2]);
    word = {rn_r.ef, rn_r.sig[24:2]} + {30'd0, up};
    if (rn_r.spec)     out_data_nxt = rn_r.spec_val;
    else if (rn_r.ovf) out_data_nxt = {rn_r.sign, 8'hFF, 23'd0};
    else               out_data_nxt = {rn_r.sign, word};
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_vld_r <= 1'b0;
      unp_vld_r <= 1'b0;
      frt_vld_r <= 1'b0;
      ads_vld_r <= 1'b0;
      for (int k = 0; k <= NSTG; k++) dv_vld_r[k] <= 1'b0;
      rn_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      sel_vld_r <= in_tvalid;
      unp_vld_r <= sel_vld_r;
      frt_vld_r <= unp_vld_r;
      ads_vld_r <= frt_vld_r;
      dv_vld_r[0] <= ads_vld_r;
      for (int k = 1; k <= NSTG; k++) dv_vld_r[k] <= dv_vld_r[k-1];
      rn_vld_r  <= dv_vld_r[NSTG];
      out_vld_r <= rn_vld_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      sel_r <= sel_nxt;
      unp_r <= unp_nxt;
      frt_r <= frt_nxt;
      ads_r <= ads_nxt;
      for (int k = 0; k <= NSTG; k++) dv_r[k] <= dv_nxt[k];
      rn_r <= rn_nxt;
      out_data_r <= out_data_nxt;
      out_last_r <= rn_r.last;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  logic [NSTG+5:0] vld_vec;
  always_comb begin
    vld_vec[0] = sel_vld_r;
    vld_vec[1] = unp_vld_r;
    vld_vec[2] = frt_vld_r;
    vld_vec[3] = ads_vld_r;
    for (int k = 0; k <= NSTG; k++) vld_vec[4+k] = dv_vld_r[k];
    vld_vec[NSTG+5] = rn_vld_r;
  end

  `FEAC_ASSERT_NXT(a_stall_holds, out_tvalid && !out_tready, $stable(vld_vec), "pipeline moved during output stall")
  `FEAC_ASSERT_IMP(a_sig_norm, rn_vld_r && !rn_r.spec && !rn_r.ovf, rn_r.sig[25] == (rn_r.ef != 8'd0), "significand not normalized before rounding")
  `FEAC_ASSERT_IMP(a_nan_canon, out_tvalid && (out_tdata[30:23] == 8'hFF) && (out_tdata[22:0] != 23'd0), out_tdata == feac_pkg::CANON_NAN, "non-canonical nan on output")

endmodule
`default_nettype wire

[dv/tb.sv]
// self-checking testbench for the binary32 element-wise add/sub/mul/div stream unit
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [31:0] value;
    logic        last;
  } result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // [31:0] first_operand, [63:32] second_operand
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [31:0] result_value
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  float_elementwise_alu_core dut (.*);

  // shadow of the block's registers
  feac_pkg::op_t cur_op;
  logic          cur_use_scalar;
  logic          cur_reverse;
  logic [31:0]   cur_scalar;

  result_t pending_results[$];
  int      fail_count;
  int      send_idle_pct;
  int      recv_stall_pct;
  int      hold_off_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("** float_elementwise_alu_core: FAILED **");
    $finish;
  end

  // widen binary32 to binary64 exactly, subnormals normalized
  function automatic logic [63:0] widen_f32(input logic [31:0] f);
    logic [23:0] mm;
    int          ex;
    if (&f[30:23]) return {f[31], 11'h7ff, f[22:0], 29'b0};
    if (f[30:0] == 31'b0) return {f[31], 63'b0};
    ex = int'(f[30:23]);
    mm = {f[30:23] != 8'd0, f[22:0]};
    if (ex == 0) begin
      ex = 1;
      while (!mm[23]) begin
        mm = mm << 1;
        ex = ex - 1;
      end
    end
    return {f[31], 11'(ex - 127 + 1023), mm[22:0], 29'b0};
  endfunction

  // round a binary64 result to binary32, nearest even; nan goes canonical
  function automatic logic [31:0] narrow_f64(input logic [63:0] d);
    logic [63:0] sig;
    logic [63:0] kept;
    logic        guard;
    logic        sticky;
    int          fe;
    int          sh;
    if (d[62:52] == 11'h7ff)
      return (d[51:0] != 52'b0) ? feac_pkg::CANON_NAN : {d[63], 8'hff, 23'b0};
    if (d[62:0] == 63'b0) return {d[63], 31'b0};
    sig = {11'b0, 1'b1, d[51:0]};
    fe = int'(d[62:52]) - 1023 + 127;
    sh = (fe >= 1) ? 29 : 30 - fe;
    if (sh > 55) sh = 55;
    kept = sig >> sh;
    guard = sig[sh-1];
    sticky = |(sig & ((64'd1 << (sh - 1)) - 64'd1));
    if (guard && (sticky || kept[0])) kept = kept + 64'd1;
    if (fe >= 1) begin
      if (kept[24]) begin
        kept = kept >> 1;
        fe = fe + 1;
      end
      if (fe >= 255) return {d[63], 8'hff, 23'b0};
      return {d[63], 8'(fe), kept[22:0]};
    end
    return {d[63], kept[30:0]};
  endfunction

  // double rounding through binary64 is exact for these four operations
  function automatic logic [31:0] float_op_result(input feac_pkg::op_t op,
                                                  input logic [31:0] x,
                                                  input logic [31:0] y);
    real a;
    real b;
    real r;
    a = $bitstoreal(widen_f32(x));
    b = $bitstoreal(widen_f32(y));
    case (op)
      feac_pkg::OP_ADD: r = a + b;
      feac_pkg::OP_DIV: r = a / b;
      feac_pkg::OP_MUL: r = a * b;
      default: r = a - b;
    endcase
    return narrow_f64($realtobits(r));
  endfunction

  function automatic logic [31:0] rand_float();
    logic [31:0] w;
    w = $urandom();
    case ($urandom_range(11))
      0: w[30:0] = 31'b0;
      1: w[30:0] = {8'hff, 23'b0};
      2: w[30:23] = 8'hff;
      3: w[30:23] = 8'h00;
      4: w[30:23] = 8'(126 + $urandom_range(2));
      5: w[30:23] = 8'(1 + $urandom_range(3));
      6: w[30:23] = 8'(250 + $urandom_range(4));
      default: ;
    endcase
    return w;
  endfunction

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      feac_pkg::REG_OP_MODE:  cur_op = feac_pkg::op_t'(value[1:0]);
      feac_pkg::REG_USE_SCAL: cur_use_scalar = value[0];
      feac_pkg::REG_REVERSE:  cur_reverse = value[0];
      default:                cur_scalar = value;
    endcase
  endtask

  task automatic set_mode(input feac_pkg::op_t op, input logic scal, input logic rev,
                          input logic [31:0] sv);
    cfg_write(feac_pkg::REG_OP_MODE, 32'(op));
    cfg_write(feac_pkg::REG_USE_SCAL, 32'(scal));
    cfg_write(feac_pkg::REG_REVERSE, 32'(rev));
    cfg_write(feac_pkg::REG_SCALAR, sv);
  endtask

  task automatic send_word(input logic [31:0] a, input logic [31:0] b, input logic last);
    result_t     r;
    logic [31:0] x;
    logic [31:0] y;
    in_tvalid <= 1'b1;
    in_tdata <= {b, a};
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    x = a;
    y = b;
    if (cur_use_scalar) begin
      x = cur_reverse ? cur_scalar : a;
      y = cur_reverse ? a : cur_scalar;
    end
    r.value = float_op_result(cur_op, x, y);
    r.last = last;
    pending_results.push_back(r);
    // keep idling while the random draw stays under the percentage, so the idle share matches it
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // checker of each result word against the oldest expectation
  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word %h", out_tdata);
        fail_count++;
      end else begin
        e = pending_results.pop_front();
        if (out_tdata !== e.value) begin
          $error("result_value expected %h actual %h", e.value, out_tdata);
          fail_count++;
        end
        if (out_tlast !== e.last) begin
          $error("result_last expected %b actual %b", e.last, out_tlast);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic test_special_values();
    logic [31:0] vals[12];
    vals = '{32'h0000_0000, 32'h8000_0000, 32'h7f80_0000, 32'hff80_0000,
             32'h7fc0_0000, 32'hffff_ffff, 32'h0000_0001, 32'h807f_ffff,
             32'h7f7f_ffff, 32'h3f80_0000, 32'h0080_0000, 32'hc040_0000};
    for (int op = 0; op < 4; op++) begin
      set_mode(feac_pkg::op_t'(op), 1'b0, 1'b1, 32'h0);
      for (int i = 0; i < 6; i++)
        send_word(vals[$urandom_range(11)], vals[$urandom_range(11)], i == 5);
      drain();
    end
    // divide by both zeros and 0/0, largest value times nan, largest value minus itself
    set_mode(feac_pkg::OP_DIV, 1'b0, 1'b0, 32'h0);
    send_word(32'h3f80_0000, 32'h8000_0000, 1'b0);
    send_word(32'hc2f6_0000, 32'h0000_0000, 1'b0);
    send_word(32'h0000_0000, 32'h0000_0000, 1'b1);
    drain();
    set_mode(feac_pkg::OP_MUL, 1'b1, 1'b0, 32'hffff_ffff);
    send_word(32'h7f7f_ffff, 32'hffff_ffff, 1'b1);
    drain();
    set_mode(feac_pkg::OP_SUB, 1'b1, 1'b1, 32'h7f7f_ffff);
    send_word(32'h7f7f_ffff, 32'h0, 1'b1);
    drain();
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int p = 0; p < 4; p++) begin
      set_mode(feac_pkg::op_t'($urandom_range(3)), 1'($urandom_range(1)),
               1'($urandom_range(1)), rand_float());
      for (int i = 0; i < 92; i++)
        send_word(rand_float(), rand_float(), $urandom_range(7) == 0);
      drain();
    end
  endtask

  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_mode(feac_pkg::OP_ADD, 1'b1, 1'b0, 32'h4049_0fdb);
    @(posedge clk);
    hold_off_cycles <= 120;
    for (int i = 0; i < 80; i++)
      send_word(rand_float(), rand_float(), i == 79);
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    cur_op = feac_pkg::OP_ADD;
    cur_use_scalar = 1'b0;
    cur_reverse = 1'b0;
    cur_scalar = '0;
    fail_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_special_values();
    test_random_phase(0, 0);
    test_random_phase(56, 0);
    test_random_phase(0, 56);
    test_random_phase(26, 26);
    test_output_backpressure();
    if (fail_count == 0) begin
      $display("** float_elementwise_alu_core: PASSED **");
    end else begin
      $display("** float_elementwise_alu_core: FAILED **");
    end
    $finish;
  end
endmodule
`default_nettype wire

[float_elementwise_alu_core.f]
+incdir+rtl
rtl/feac_pkg.sv
rtl/float_elementwise_alu_core.sv
dv/tb.sv
